FILE: design/int2dec_pkg.sv
package int2dec_pkg;

   localparam int DefaultValueBits = 32;

   // ASCII codes
   localparam logic [7:0] DigitZero = 8'h30;
   localparam logic [7:0] MinusSign = 8'h2D;

   // Double-dabble: a BCD digit at or above this value is corrected before the shift
   localparam logic [3:0] BcdAdjLimit = 4'd5;
   localparam logic [3:0] BcdAdjAdd   = 4'd3;

   // Handoff from the converter to the character emitter
   typedef struct packed {
      logic load;
      logic negative;
   } emit_cmd_type;

endpackage

FILE: design/int_to_decimal_ascii_unit.sv
// Integer to decimal ASCII text. A transaction is accepted when start is high
// and busy is low; req_command selects unsigned (0) or two's-complement signed
// (1) reading of req_value. The text comes out one character per rsp_strobe
// pulse, most significant digit first, a minus sign ahead of negative values,
// rsp_last marking the final character; zero gives a single '0' and the most
// negative value prints exactly. The receiver cannot stall: every strobed
// character must be taken in its cycle. One transaction at a time: busy stays
// high from acceptance until the last character is out. Conversion is
// bit-serial double-dabble, one input bit per cycle, followed by a pass over
// the BCD digit positions (leading zeros skipped, then sign, then digits), of
// which there are NUM_DIGITS = 10 at VALUE_BITS = 32.
module int_to_decimal_ascii_unit
   import int2dec_pkg::*;
#(
   parameter int VALUE_BITS = DefaultValueBits
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_strobe,
   output logic [7:0]            rsp_character,
   output logic                  rsp_last
);

   // decimal digits needed for 2^VALUE_BITS - 1 (log10(2) ~ 0.30103)
   localparam int NumDigits = (VALUE_BITS * 30103) / 100000 + 1;

   typedef enum logic [1:0] {
      IDLE,
      CONV,
      EMIT
   } state_type;

   state_type              state_ff;
   logic                   neg_ff;
   logic                   accept;
   logic                   negative;
   logic [VALUE_BITS-1:0]  magnitude;
   logic                   conv_done;
   logic [NumDigits*4-1:0] bcd;
   logic                   emit_done;
   emit_cmd_type           emit_cmd;

   assign accept   = start && (state_ff == IDLE);
   assign busy     = (state_ff != IDLE);
   assign negative = req_command && req_value[VALUE_BITS-1];
   // unsigned negate, so the most negative value yields 2^(VALUE_BITS-1)
   assign magnitude = negative ? (~req_value + VALUE_BITS'(1)) : req_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  neg_ff   <= negative;
                  state_ff <= CONV;
               end
            end
            CONV: begin
               if (conv_done) begin
                  state_ff <= EMIT;
               end
            end
            EMIT: begin
               if (emit_done) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign emit_cmd.load     = conv_done;
   assign emit_cmd.negative = neg_ff;

   int2dec_bcd #(
      .VALUE_BITS (VALUE_BITS),
      .NUM_DIGITS (NumDigits)
   ) u_bcd (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .magnitude (magnitude),
      .done      (conv_done),
      .bcd       (bcd)
   );

   int2dec_emit #(
      .NUM_DIGITS (NumDigits)
   ) u_emit (
      .clock     (clock),
      .reset     (reset),
      .cmd       (emit_cmd),
      .bcd       (bcd),
      .strobe    (rsp_strobe),
      .character (rsp_character),
      .last      (rsp_last),
      .done      (emit_done)
   );

endmodule

FILE: design/int2dec_bcd.sv
module int2dec_bcd
   import int2dec_pkg::*;
#(
   parameter int VALUE_BITS = DefaultValueBits,
   parameter int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  logic [VALUE_BITS-1:0]     magnitude,
   output logic                      done,
   output logic [NUM_DIGITS*4-1:0]   bcd
);

   localparam int BcdW = NUM_DIGITS * 4;
   localparam int CntW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic [BcdW-1:0]       bcd_ff, bcd_in, adj;
   logic [CntW-1:0]       count_ff, count_in;
   logic                  active_ff, active_in;
   logic                  done_ff, done_in;

   // one binary bit enters per cycle; each digit corrected in parallel
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= BcdAdjLimit) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + BcdAdjAdd;
         end
      end

      bin_in    = bin_ff;
      bcd_in    = bcd_ff;
      count_in  = count_ff;
      active_in = active_ff;
      done_in   = 1'b0;

      if (load) begin
         bin_in    = magnitude;
         bcd_in    = '0;
         count_in  = CntW'(VALUE_BITS);
         active_in = 1'b1;
      end else if (active_ff) begin
         bcd_in   = {adj[BcdW-2:0], bin_ff[VALUE_BITS-1]};
         bin_in   = {bin_ff[VALUE_BITS-2:0], 1'b0};
         count_in = count_ff - CntW'(1);
         if (count_ff == CntW'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

FILE: design/int2dec_emit.sv
module int2dec_emit
   import int2dec_pkg::*;
#(
   parameter int NUM_DIGITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  emit_cmd_type            cmd,
   input  logic [NUM_DIGITS*4-1:0] bcd,
   output logic                    strobe,
   output logic [7:0]              character,
   output logic                    last,
   output logic                    done
);

   localparam int BcdW = NUM_DIGITS * 4;
   localparam int RemW = $clog2(NUM_DIGITS + 1);

   typedef enum logic [1:0] {
      IDLE,
      SKIP,
      SIGN,
      DIGIT
   } state_type;

   state_type       state_ff;
   logic [BcdW-1:0] bcd_ff;
   logic [RemW-1:0] rem_ff;
   logic            neg_ff;
   logic            strobe_ff;
   logic [7:0]      char_ff;
   logic            last_ff;
   logic            done_ff;
   logic [3:0]      top_digit;

   assign top_digit = bcd_ff[BcdW-1 -: 4];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= IDLE;
         strobe_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         done_ff   <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (cmd.load) begin
                  bcd_ff   <= bcd;
                  rem_ff   <= RemW'(NUM_DIGITS);
                  neg_ff   <= cmd.negative;
                  state_ff <= SKIP;
               end
            end
            SKIP: begin
               // drop leading zeros, keep at least one digit
               if (top_digit == 4'd0 && rem_ff != RemW'(1)) begin
                  bcd_ff <= {bcd_ff[BcdW-5:0], 4'd0};
                  rem_ff <= rem_ff - RemW'(1);
               end else if (neg_ff) begin
                  state_ff <= SIGN;
               end else begin
                  state_ff <= DIGIT;
               end
            end
            SIGN: begin
               strobe_ff <= 1'b1;
               char_ff   <= MinusSign;
               last_ff   <= 1'b0;
               state_ff  <= DIGIT;
            end
            DIGIT: begin
               strobe_ff <= 1'b1;
               char_ff   <= {4'd0, top_digit} + DigitZero;
               last_ff   <= (rem_ff == RemW'(1));
               bcd_ff    <= {bcd_ff[BcdW-5:0], 4'd0};
               rem_ff    <= rem_ff - RemW'(1);
               if (rem_ff == RemW'(1)) begin
                  done_ff  <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign strobe    = strobe_ff;
   assign character = char_ff;
   assign last      = last_ff;
   assign done      = done_ff;

endmodule
